### rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEFAULT_DEPTH       = 128;
   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int DEFAULT_PRIO_WIDTH  = 8;

   localparam int STATUS_WIDTH = 2;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic enq;
      logic deq;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/sorted_priority_queue_unit.sv
// response: a request's response is registered and shown in the cycle after acceptance
// throughput: one request per cycle, enqueue or dequeue, while no held response stalls requests;
//    set by the cell chain where every slot shifts by at most one place per cycle
// reset: synchronous, clears the entry count and response valid; slot
//    contents are left as they are and are only read below the count
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue kept sorted in a chain of cells, highest priority at head.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
   parameter int DEPTH       = spq_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = spq_pkg::DEFAULT_VALUE_WIDTH,
   parameter int PRIO_WIDTH  = spq_pkg::DEFAULT_PRIO_WIDTH,
   parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_type,
   input  wire [VALUE_WIDTH-1:0]               req_item_value,
   input  wire [PRIO_WIDTH-1:0]                req_item_priority,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [VALUE_WIDTH-1:0]              rsp_out_value,
   output logic [PRIO_WIDTH-1:0]               rsp_out_priority,
   output logic [spq_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [COUNT_WIDTH-1:0]              rsp_entry_count
);
   import spq_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   logic                    accept;
   logic                    full;
   logic                    empty;
   cmd_type                 cmd;

   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [COUNT_WIDTH-1:0]  count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff;
   logic [VALUE_WIDTH-1:0]  rsp_value_in;
   logic [PRIO_WIDTH-1:0]   rsp_prio_ff;
   logic [PRIO_WIDTH-1:0]   rsp_prio_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff;
   logic [STATUS_WIDTH-1:0] rsp_status_in;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff;
   logic [COUNT_WIDTH-1:0]  rsp_count_in;

   logic [DEPTH-1:0]        cell_lower;
   logic [VALUE_WIDTH-1:0]  cell_value [DEPTH];
   logic [PRIO_WIDTH-1:0]   cell_prio  [DEPTH];

   // a waiting response only blocks if the consumer holds it
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);

   assign cmd.enq = accept && (req_type == REQ_ENQUEUE) && !full;
   assign cmd.deq = accept && (req_type == REQ_DEQUEUE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                   prev_lower;
      logic [VALUE_WIDTH-1:0] prev_value;
      logic [PRIO_WIDTH-1:0]  prev_prio;
      logic [VALUE_WIDTH-1:0] next_value;
      logic [PRIO_WIDTH-1:0]  next_prio;

      if (i == 0) begin : g_head
         assign prev_lower = 1'b0;
         assign prev_value = req_item_value;
         assign prev_prio  = req_item_priority;
      end else begin : g_body
         assign prev_lower = cell_lower[i-1];
         assign prev_value = cell_value[i-1];
         assign prev_prio  = cell_prio[i-1];
      end

      // tail slot refills with its own contents, now beyond the count
      if (i == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[i];
         assign next_prio  = cell_prio[i];
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_prio  = cell_prio[i+1];
      end

      spq_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .PRIO_WIDTH  (PRIO_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (COUNT_WIDTH'(i) < count_ff),
         .ins_value  (req_item_value),
         .ins_prio   (req_item_priority),
         .prev_lower (prev_lower),
         .prev_value (prev_value),
         .prev_prio  (prev_prio),
         .next_value (next_value),
         .next_prio  (next_prio),
         .lower      (cell_lower[i]),
         .value      (cell_value[i]),
         .prio       (cell_prio[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_prio_in   = '0;
         rsp_status_in = STATUS_OK;
         if (req_type == REQ_ENQUEUE) begin
            if (full) begin
               rsp_status_in = STATUS_OVERFLOW;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               rsp_status_in = STATUS_UNDERFLOW;
            end else begin
               rsp_value_in = cell_value[0];
               rsp_prio_in  = cell_prio[0];
               count_in     = count_ff - 1'b1;
            end
         end
         rsp_count_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > FULL_COUNT, "entry count above depth")
   `ASSERT_AT(a_head_order, clock, reset, (count_ff < COUNT_WIDTH'(2)) || (cell_prio[0] >= cell_prio[1]), "head pair out of order")
   `ASSERT_AT(a_overflow_full, clock, reset, !(rsp_valid_ff && rsp_status_ff == STATUS_OVERFLOW) || (rsp_count_ff == FULL_COUNT), "overflow reported below depth")
   `ASSERT_AT(a_underflow_empty, clock, reset, !(rsp_valid_ff && rsp_status_ff == STATUS_UNDERFLOW) || (rsp_count_ff == '0), "underflow reported with entries held")
   `ASSERT_AT(a_count_step, clock, reset, !accept || (count_in == count_ff) || (count_in == count_ff + 1'b1) || (count_in == count_ff - 1'b1), "count moved by more than one")

endmodule
`default_nettype wire

### rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a pair and moves it to a neighbour.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int VALUE_WIDTH = spq_pkg::DEFAULT_VALUE_WIDTH,
   parameter int PRIO_WIDTH  = spq_pkg::DEFAULT_PRIO_WIDTH
) (
   input  wire                   clock,
   input  spq_pkg::cmd_type      cmd,
   input  wire                   occupied,
   input  wire [VALUE_WIDTH-1:0] ins_value,
   input  wire [PRIO_WIDTH-1:0]  ins_prio,
   input  wire                   prev_lower,
   input  wire [VALUE_WIDTH-1:0] prev_value,
   input  wire [PRIO_WIDTH-1:0]  prev_prio,
   input  wire [VALUE_WIDTH-1:0] next_value,
   input  wire [PRIO_WIDTH-1:0]  next_prio,
   output logic                  lower,
   output logic [VALUE_WIDTH-1:0] value,
   output logic [PRIO_WIDTH-1:0]  prio
);
   import spq_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   logic [PRIO_WIDTH-1:0]  prio_ff;
   logic [PRIO_WIDTH-1:0]  prio_in;

   // new pair goes behind every entry of equal or higher priority
   assign lower = !occupied || (prio_ff < ins_prio);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (cmd.deq) begin
         value_in = next_value;
         prio_in  = next_prio;
      end else if (cmd.enq && lower) begin
         if (prev_lower) begin
            value_in = prev_value;
            prio_in  = prev_prio;
         end else begin
            value_in = ins_value;
            prio_in  = ins_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value = value_ff;
   assign prio  = prio_ff;

endmodule
`default_nettype wire
